// File: rtl/nns_pkg.sv
// ----------------------------------------------------------------------------
// nns_pkg: shared constants of the nearest-neighbor scaler
// Field widths, command and register codes, beat widths, and dimension clamp.
// ----------------------------------------------------------------------------
package nns_pkg;

    localparam int COORD_W  = 10;
    localparam int CH_W     = 8;
    localparam int PIX_W    = 3 * CH_W;
    localparam int SW_W     = 9;
    localparam int DW_W     = 11;
    localparam int PROD_W   = COORD_W + SW_W;
    localparam int CFG_A_W  = 2;
    localparam int CFG_D_W  = DW_W;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 24;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    localparam logic [CFG_A_W-1:0] REG_SRC_WIDTH  = 2'd0;
    localparam logic [CFG_A_W-1:0] REG_SRC_HEIGHT = 2'd1;
    localparam logic [CFG_A_W-1:0] REG_DST_WIDTH  = 2'd2;
    localparam logic [CFG_A_W-1:0] REG_DST_HEIGHT = 2'd3;

    localparam logic [DW_W-1:0] DIM_RESET = 11'd256;

    function automatic logic [DW_W-1:0] clamp_dim(input logic [DW_W-1:0] v,
                                                   input logic [DW_W-1:0] vmax);
        logic [DW_W-1:0] res;
        if (v == '0) begin
            res = {{(DW_W-1){1'b0}}, 1'b1};
        end else if (v > vmax) begin
            res = vmax;
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

// File: rtl/nns_div_lane.sv
// ----------------------------------------------------------------------------
// nns_div_lane: pipelined restoring divider lane
// One quotient bit per stage, most significant first; skipped beats keep their
// preloaded quotient.
// ----------------------------------------------------------------------------
module nns_div_lane #(
    parameter int QW = 8
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [nns_pkg::DW_W+QW-1:0]  i_dividend,
    input  logic [nns_pkg::DW_W-1:0]     i_divisor,
    input  logic [QW-1:0]                i_q_init,
    input  logic                         i_skip,
    output logic [QW-1:0]                o_quot
);
    import nns_pkg::*;

    localparam int RW = DW_W + QW;

    logic [RW-1:0] r_rem  [QW];
    logic [QW-1:0] r_q    [QW];
    logic          r_skip [QW];

    logic [RW-1:0] n_rem  [QW];
    logic [QW-1:0] n_q    [QW];
    logic          n_skip [QW];

    always_comb begin
        logic [RW-1:0] rem_in;
        logic [QW-1:0] q_in;
        logic          skip_in;
        logic [RW-1:0] d_sh;
        for (int k = 0; k < QW; k++) begin
            if (k == 0) begin
                rem_in  = i_dividend;
                q_in    = i_q_init;
                skip_in = i_skip;
            end else begin
                rem_in  = r_rem[k-1];
                q_in    = r_q[k-1];
                skip_in = r_skip[k-1];
            end
            d_sh      = RW'(i_divisor) << (QW - 1 - k);
            n_rem[k]  = rem_in;
            n_q[k]    = q_in;
            n_skip[k] = skip_in;
            if (!skip_in && (rem_in >= d_sh)) begin
                n_rem[k]           = rem_in - d_sh;
                n_q[k][QW - 1 - k] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < QW; k++) begin
                r_rem[k]  <= n_rem[k];
                r_q[k]    <= n_q[k];
                r_skip[k] <= n_skip[k];
            end
        end
    end

    assign o_quot = r_q[QW-1];

endmodule

// File: rtl/nearest_neighbor_scaler_unit.sv
// ----------------------------------------------------------------------------
// nearest_neighbor_scaler_unit: nearest-neighbor scaler over a stored frame
// One beat per cycle while the output is not stalled; a read result passes the
// input, product, QW divider and frame-read registers, QW being the quotient width. Synchronous reset
// clears valids and restores default sizes; frame contents stay undefined.
// ----------------------------------------------------------------------------
module nearest_neighbor_scaler_unit #(
    parameter int MAX_SRC_WIDTH  = 256,
    parameter int MAX_SRC_HEIGHT = 256,
    parameter int MAX_DST_DIM    = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [nns_pkg::CFG_A_W-1:0]     i_cfg_addr,
    input  logic [nns_pkg::CFG_D_W-1:0]     i_cfg_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // coord_x, coord_y, in_blue, in_green, in_red, zero fill
    input  logic [nns_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // cmd
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // out_blue, out_green, out_red
    output logic [nns_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // range_error
    output logic                            m_axis_tuser
);
    import nns_pkg::*;

    localparam int MAXS  = (MAX_SRC_WIDTH > MAX_SRC_HEIGHT) ? MAX_SRC_WIDTH : MAX_SRC_HEIGHT;
    localparam int QW    = (MAXS > 1) ? $clog2(MAXS) : 1;
    localparam int RW    = DW_W + QW;
    localparam int DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NS    = QW + 3;
    localparam int ST_M  = QW + 2;

    localparam logic [DW_W-1:0] SW_LIM = DW_W'((MAX_SRC_WIDTH > 511) ? 511 : MAX_SRC_WIDTH);
    localparam logic [DW_W-1:0] SH_LIM = DW_W'((MAX_SRC_HEIGHT > 511) ? 511 : MAX_SRC_HEIGHT);
    localparam logic [DW_W-1:0] DD_LIM = DW_W'((MAX_DST_DIM > 2047) ? 2047 : MAX_DST_DIM);

    typedef struct packed {
        logic             cmd;
        logic             ok;
        logic             err;
        logic [PIX_W-1:0] pix;
    } t_beat;

    logic [SW_W-1:0]    r_sw, r_sh;
    logic [DW_W-1:0]    r_dw, r_dh;

    logic [NS-1:0]      r_vld;
    t_beat              r_pl [NS];
    logic [COORD_W-1:0] r_x, r_y;
    logic [PROD_W-1:0]  r_px, r_py;
    logic [QW-1:0]      r_qx, r_qy;

    logic [PIX_W-1:0]   r_frame [DEPTH];
    logic [PIX_W-1:0]   r_rd;

    logic               en;
    logic               out_vld;
    t_beat              n_beat;
    logic [COORD_W-1:0] in_x, in_y;
    logic [QW-1:0]      sx, sy;
    logic [AW-1:0]      n_addr;
    logic               at_mem;

    // configuration, stored already clamped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw <= SW_W'(clamp_dim(DIM_RESET, SW_LIM));
            r_sh <= SW_W'(clamp_dim(DIM_RESET, SH_LIM));
            r_dw <= clamp_dim(DIM_RESET, DD_LIM);
            r_dh <= clamp_dim(DIM_RESET, DD_LIM);
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_SRC_WIDTH: begin
                    r_sw <= SW_W'(clamp_dim(DW_W'(i_cfg_data[SW_W-1:0]), SW_LIM));
                end
                REG_SRC_HEIGHT: begin
                    r_sh <= SW_W'(clamp_dim(DW_W'(i_cfg_data[SW_W-1:0]), SH_LIM));
                end
                REG_DST_WIDTH: begin
                    r_dw <= clamp_dim(i_cfg_data, DD_LIM);
                end
                REG_DST_HEIGHT: begin
                    r_dh <= clamp_dim(i_cfg_data, DD_LIM);
                end
                default: begin
                end
            endcase
        end
    end

    assign out_vld       = r_vld[ST_M] && (r_pl[ST_M].cmd == CMD_READ);
    assign en            = !out_vld || m_axis_tready;
    assign s_axis_tready = en;

    assign in_x = s_axis_tdata[COORD_W-1:0];
    assign in_y = s_axis_tdata[2*COORD_W-1:COORD_W];

    always_comb begin
        n_beat.cmd = s_axis_tuser;
        n_beat.pix = s_axis_tdata[2*COORD_W+PIX_W-1:2*COORD_W];
        n_beat.err = (DW_W'(in_x) >= r_dw) || (DW_W'(in_y) >= r_dh);
        if (s_axis_tuser == CMD_WRITE) begin
            n_beat.ok = (in_x < COORD_W'(r_sw)) && (in_y < COORD_W'(r_sh));
        end else begin
            n_beat.ok = !n_beat.err;
        end
    end

    // advance the whole line on each enabled cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NS-2:0], s_axis_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pl[0] <= n_beat;
            for (int k = 1; k < NS; k++) begin
                r_pl[k] <= r_pl[k-1];
            end
            r_x  <= in_x;
            r_y  <= in_y;
            r_px <= PROD_W'(r_x) * PROD_W'(r_sw);
            r_py <= PROD_W'(r_y) * PROD_W'(r_sh);
            r_qx <= (r_pl[0].cmd == CMD_WRITE) ? QW'(r_x) : '0;
            r_qy <= (r_pl[0].cmd == CMD_WRITE) ? QW'(r_y) : '0;
        end
    end

    nns_div_lane #(.QW(QW)) u_div_x (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_dividend (RW'(r_px)),
        .i_divisor  (r_dw),
        .i_q_init   (r_qx),
        .i_skip     (r_pl[1].cmd == CMD_WRITE),
        .o_quot     (sx)
    );

    nns_div_lane #(.QW(QW)) u_div_y (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_dividend (RW'(r_py)),
        .i_divisor  (r_dh),
        .i_q_init   (r_qy),
        .i_skip     (r_pl[1].cmd == CMD_WRITE),
        .o_quot     (sy)
    );

    assign n_addr = AW'(32'(sy) * MAX_SRC_WIDTH + 32'(sx));
    assign at_mem = en && r_vld[QW+1] && r_pl[QW+1].ok;

    always_ff @(posedge i_clk) begin
        if (at_mem && (r_pl[QW+1].cmd == CMD_WRITE)) begin
            r_frame[n_addr] <= r_pl[QW+1].pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (at_mem && (r_pl[QW+1].cmd == CMD_READ)) begin
            r_rd <= r_frame[n_addr];
        end
    end

    assign m_axis_tvalid = out_vld;
    assign m_axis_tdata  = r_pl[ST_M].err ? '0 : r_rd;
    assign m_axis_tuser  = r_pl[ST_M].err;

endmodule

// File: bench/nearest_neighbor_scaler_unit_test.sv
// ----------------------------------------------------------------------------
// nearest_neighbor_scaler_unit_test: self-checking bench for the scaler
// Streams source pixel writes and output pixel reads through several source
// and output sizes, and predicts each read beat from a private copy of the
// frame. Every returned beat is compared field by field, in order.
// ----------------------------------------------------------------------------
module nearest_neighbor_scaler_unit_test;

    localparam int FRAME_COLS    = 256;
    localparam int FRAME_ROWS    = 256;
    localparam int DST_MAX       = 1024;
    localparam int SETTLE_CYCLES = 64;
    localparam int STALL_LIMIT   = 4000;
    localparam int REPORT_CAP    = 200;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       range_err;
    } scaled_pixel_t;

    class pixel_scoreboard;
        logic [23:0]   frame_mem [0:FRAME_COLS*FRAME_ROWS-1];
        bit            written   [0:FRAME_COLS*FRAME_ROWS-1];
        logic [8:0]    src_w;
        logic [8:0]    src_h;
        logic [10:0]   dst_w;
        logic [10:0]   dst_h;
        scaled_pixel_t pending_pixels [$];
        int            mismatches;
        int            pixel_writes;
        int            pixel_reads;
        int            off_frame_reads;

        function new();
            src_w           = 9'd256;
            src_h           = 9'd256;
            dst_w           = 11'd256;
            dst_h           = 11'd256;
            mismatches      = 0;
            pixel_writes    = 0;
            pixel_reads     = 0;
            off_frame_reads = 0;
        endfunction

        function void set_reg(logic [nns_pkg::CFG_A_W-1:0] idx,
                              logic [nns_pkg::CFG_D_W-1:0] data);
            case (idx)
                nns_pkg::REG_SRC_WIDTH:  src_w = data[8:0];
                nns_pkg::REG_SRC_HEIGHT: src_h = data[8:0];
                nns_pkg::REG_DST_WIDTH:  dst_w = data;
                nns_pkg::REG_DST_HEIGHT: dst_h = data;
                default: ;
            endcase
        endfunction

        function int unsigned span(int unsigned v, int unsigned top);
            if (v == 0) return 1;
            if (v > top) return top;
            return v;
        endfunction

        function void dims(output int unsigned sw, output int unsigned sh,
                           output int unsigned dw, output int unsigned dh);
            sw = span(32'(src_w), FRAME_COLS);
            sh = span(32'(src_h), FRAME_ROWS);
            dw = span(32'(dst_w), DST_MAX);
            dh = span(32'(dst_h), DST_MAX);
        endfunction

        // map an output coordinate onto its source entry
        function bit source_of(logic [9:0] x, logic [9:0] y, output int unsigned addr);
            int unsigned sw, sh, dw, dh;
            dims(sw, sh, dw, dh);
            addr = 0;
            if (x >= dw || y >= dh) return 0;
            addr = ((y * sh) / dh) * FRAME_COLS + (x * sw) / dw;
            return 1;
        endfunction

        function void note_beat(logic cmd, logic [9:0] x, logic [9:0] y, logic [23:0] pix);
            int unsigned   sw, sh, dw, dh, addr;
            scaled_pixel_t res;
            dims(sw, sh, dw, dh);
            if (cmd == nns_pkg::CMD_WRITE) begin
                pixel_writes++;
                if (x < sw && y < sh) begin
                    addr            = y * FRAME_COLS + x;
                    frame_mem[addr] = pix;
                    written[addr]   = 1'b1;
                end
            end else begin
                pixel_reads++;
                if (source_of(x, y, addr)) begin
                    {res.red, res.green, res.blue} = frame_mem[addr];
                    res.range_err = 1'b0;
                end else begin
                    res           = '0;
                    res.range_err = 1'b1;
                    off_frame_reads++;
                end
                pending_pixels.push_back(res);
            end
        endfunction

        task report(string what);
            mismatches++;
            // cap the log for a badly broken block
            if (mismatches <= REPORT_CAP) $display("mismatch: %s", what);
        endtask

        task check_result(logic [23:0] data, logic err);
            scaled_pixel_t want;
            if (pending_pixels.size() == 0) begin
                report($sformatf("result beat %h err %b with no read waiting", data, err));
                return;
            end
            want = pending_pixels.pop_front();
            if (data[7:0] !== want.blue)
                report($sformatf("blue %h, predicted %h", data[7:0], want.blue));
            if (data[15:8] !== want.green)
                report($sformatf("green %h, predicted %h", data[15:8], want.green));
            if (data[23:16] !== want.red)
                report($sformatf("red %h, predicted %h", data[23:16], want.red));
            if (err !== want.range_err)
                report($sformatf("range error %b, predicted %b", err, want.range_err));
        endtask

        function int pending();
            return pending_pixels.size();
        endfunction
    endclass

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              i_cfg_we;
    logic [nns_pkg::CFG_A_W-1:0]       i_cfg_addr;
    logic [nns_pkg::CFG_D_W-1:0]       i_cfg_data;
    logic                              s_axis_tvalid;
    logic                              s_axis_tready;
    logic [nns_pkg::S_TDATA_W-1:0]     s_axis_tdata;
    logic                              s_axis_tuser;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b1;
    logic [nns_pkg::M_TDATA_W-1:0]     m_axis_tdata;
    logic                              m_axis_tuser;

    pixel_scoreboard sb = new();
    int              gap_pct = 9;
    int              settings_run = 0;
    int              stall_cycles = 0;

    nearest_neighbor_scaler_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        m_axis_tready = ($urandom_range(0, 99) >= gap_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_result(m_axis_tdata, m_axis_tuser);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // enter and leave at a falling edge; tvalid stays high for a following beat
    task automatic send_beat(logic cmd, logic [9:0] x, logic [9:0] y, logic [23:0] pix);
        while ($urandom_range(0, 99) < gap_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = cmd;
        s_axis_tdata  = {4'b0, pix, y, x};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_beat(cmd, x, y, pix);
        @(negedge i_clk);
    endtask

    task automatic wait_drain();
        s_axis_tvalid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [nns_pkg::CFG_A_W-1:0] idx,
                             logic [nns_pkg::CFG_D_W-1:0] data);
        i_cfg_we   = 1'b1;
        i_cfg_addr = idx;
        i_cfg_data = data;
        sb.set_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
    endtask

    task automatic set_sizes(logic [10:0] sw, logic [10:0] sh, logic [10:0] dw, logic [10:0] dh);
        wait_drain();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        write_reg(nns_pkg::REG_SRC_WIDTH, sw);
        write_reg(nns_pkg::REG_SRC_HEIGHT, sh);
        write_reg(nns_pkg::REG_DST_WIDTH, dw);
        write_reg(nns_pkg::REG_DST_HEIGHT, dh);
        settings_run++;
    endtask

    // fill the selected source entry first if it was never written
    task automatic issue_read(logic [9:0] x, logic [9:0] y);
        int unsigned addr;
        if (sb.source_of(x, y, addr) && !sb.written[addr]) begin
            send_beat(nns_pkg::CMD_WRITE, 10'(addr % FRAME_COLS), 10'(addr / FRAME_COLS),
                      24'($urandom()));
        end
        send_beat(nns_pkg::CMD_READ, x, y, 24'($urandom()));
    endtask

    task automatic run_phase(logic [10:0] sw, logic [10:0] sh, logic [10:0] dw,
                             logic [10:0] dh, int count);
        int unsigned esw, esh, edw, edh;
        int          hold_at;
        int          roll;
        set_sizes(sw, sh, dw, dh);
        sb.dims(esw, esh, edw, edh);
        hold_at = $urandom_range(1, count - 1);
        for (int n = 0; n < count; n++) begin
            if (n == hold_at) wait_drain();
            roll = $urandom_range(0, 99);
            if (roll < 30) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_beat(nns_pkg::CMD_WRITE, 10'($urandom_range(0, 1023)),
                              10'($urandom_range(0, 1023)), 24'($urandom()));
                end else begin
                    send_beat(nns_pkg::CMD_WRITE, 10'($urandom_range(0, esw - 1)),
                              10'($urandom_range(0, esh - 1)), 24'($urandom()));
                end
            end else if (roll < 85) begin
                issue_read(10'($urandom_range(0, edw - 1)), 10'($urandom_range(0, edh - 1)));
            end else begin
                issue_read(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
            end
        end
    endtask

    initial begin
        int          idx;
        logic [10:0] rsw, rsh, rdw, rdh;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = nns_pkg::CMD_WRITE;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: 4x3 source shown as 9x7
        set_sizes(11'd4, 11'd3, 11'd9, 11'd7);
        for (int y = 0; y < 3; y++) begin
            for (int x = 0; x < 4; x++) begin
                idx = y * 4 + x;
                if (idx == 0) begin
                    send_beat(nns_pkg::CMD_WRITE, 10'(x), 10'(y), 24'h000000);
                end else if (idx == 11) begin
                    send_beat(nns_pkg::CMD_WRITE, 10'(x), 10'(y), 24'hFFFFFF);
                end else begin
                    send_beat(nns_pkg::CMD_WRITE, 10'(x), 10'(y),
                              {8'(idx * 23), 8'(255 - idx * 19), 8'(idx * 41)});
                end
            end
        end
        send_beat(nns_pkg::CMD_WRITE, 10'd4, 10'd0, 24'hABCDEF);
        send_beat(nns_pkg::CMD_WRITE, 10'd1023, 10'd1023, 24'hFFFFFF);
        issue_read(10'd0, 10'd0);
        issue_read(10'd8, 10'd6);
        issue_read(10'd4, 10'd3);
        issue_read(10'd9, 10'd0);
        issue_read(10'd0, 10'd7);
        issue_read(10'd1023, 10'd1023);
        send_beat(nns_pkg::CMD_WRITE, 10'd3, 10'd2, 24'h5A5AA5);
        issue_read(10'd8, 10'd6);

        gap_pct = 0;
        run_phase(11'd256, 11'd256, 11'd1024, 11'd1024, 130);
        gap_pct = 9;
        run_phase(11'd0, 11'd0, 11'd0, 11'd0, 45);
        run_phase(11'd511, 11'd511, 11'd2047, 11'd2047, 110);
        run_phase(11'd256, 11'd256, 11'd1, 11'd1, 60);
        run_phase(11'd1, 11'd1, 11'd1024, 11'd1024, 70);
        run_phase(11'd7, 11'd5, 11'd13, 11'd11, 115);
        run_phase(11'd2047, 11'd2047, 11'd0, 11'd2047, 70);
        for (int p = 0; p < 4; p++) begin
            rsw = ($urandom_range(0, 4) == 0) ? 11'($urandom_range(0, 2047))
                                              : 11'($urandom_range(1, 64));
            rsh = ($urandom_range(0, 4) == 0) ? 11'($urandom_range(0, 2047))
                                              : 11'($urandom_range(1, 64));
            rdw = ($urandom_range(0, 4) == 0) ? 11'($urandom_range(0, 2047))
                                              : 11'($urandom_range(1, 1024));
            rdh = ($urandom_range(0, 4) == 0) ? 11'($urandom_range(0, 2047))
                                              : 11'($urandom_range(1, 1024));
            run_phase(rsw, rsh, rdw, rdh, 80);
        end

        wait_drain();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (sb.pending() != 0) sb.report($sformatf("%0d reads never answered", sb.pending()));

        $display("Ran %0d size settings with %0d pixel writes and %0d pixel reads",
                 settings_run, sb.pixel_writes, sb.pixel_reads);
        $display("(%0d off frame); sizes spanned 1x1 to 256x256 source and 1x1 to %s",
                 sb.off_frame_reads, "1024x1024 output, zero and oversized registers included.");
        if (sb.mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
